// ===== hw/rtl/csub_pkg.sv =====
// Shared types and constants of the cubic B-spline curve subdivider.
package csub_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      logic      end_of_curve;
   } req_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      coord_type out_z;
      logic      final_point;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_FIRST,
      KIND_MID,
      KIND_FULL
   } kind_type;

   // One classified request as handed from the front end to the back end.
   typedef struct packed {
      kind_type        kind;
      logic            last;
      coord_type [2:0] p0;
      coord_type [2:0] p1;
      coord_type [2:0] p2;
   } work_type;

endpackage

// ===== hw/rtl/csub_front.sv =====
// Front end: accepts requests, keeps the point history and classifies each request.
module csub_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  csub_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output csub_pkg::work_type q_data
);
   import csub_pkg::*;

   coord_type [2:0] older_ff, older_in;
   coord_type [2:0] newer_ff, newer_in;
   logic [1:0]      seen_ff, seen_in;
   coord_type [2:0] cur;
   logic            accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = accept;

   always_comb begin
      cur[0] = req_data.point_x;
      cur[1] = req_data.point_y;
      cur[2] = req_data.point_z;

      q_data.last = req_data.end_of_curve;
      q_data.p0   = older_ff;
      q_data.p1   = newer_ff;
      q_data.p2   = cur;
      case (seen_ff)
         2'd0:    q_data.kind = KIND_FIRST;
         2'd1:    q_data.kind = KIND_MID;
         default: q_data.kind = KIND_FULL;
      endcase

      older_in = older_ff;
      newer_in = newer_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (req_data.end_of_curve) begin
            older_in = '0;
            newer_in = '0;
            seen_in  = 2'd0;
         end else begin
            older_in = newer_ff;
            newer_in = cur;
            if (seen_ff != 2'd2) begin
               seen_in = seen_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
         seen_ff  <= 2'd0;
      end else begin
         older_ff <= older_in;
         newer_ff <= newer_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ===== hw/rtl/csub_queue.sv =====
// Short queue of classified requests between the front end and the back end.
module csub_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  csub_pkg::work_type wr_data,
   input  logic               pop,
   output logic               empty,
   output csub_pkg::work_type rd_data
);
   import csub_pkg::*;

   work_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/csub_back.sv =====
// Back end: expands each classified request into refined points, one per cycle while the consumer pops them.
module csub_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  csub_pkg::work_type q_data,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output csub_pkg::rsp_type  rsp_data
);
   import csub_pkg::*;

   logic [1:0]      step_ff, step_in;
   logic            valid_ff, valid_in;
   rsp_type         out_ff, out_in;
   logic [1:0]      last_step;
   logic            advance;
   logic            take_cur;
   logic            take_vertex;
   coord_type [2:0] res;
   logic signed [COORD_WIDTH+2:0] vsum [3];
   logic signed [COORD_WIDTH:0]   msum [3];

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;
   assign advance   = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop     = advance && (step_ff == last_step);

   always_comb begin
      case (q_data.kind)
         KIND_FIRST: last_step = 2'd0;
         KIND_MID:   last_step = {1'b0, q_data.last};
         KIND_FULL:  last_step = q_data.last ? 2'd2 : 2'd1;
         default:    last_step = 2'd0;
      endcase
   end

   // The unchanged point closes a curve; a first point is always passed through.
   assign take_cur    = (step_ff == last_step) &&
                        (q_data.last || (q_data.kind != KIND_MID && q_data.kind != KIND_FULL));
   assign take_vertex = (q_data.kind == KIND_FULL) && (step_ff == 2'd0);

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         vsum[j] = (COORD_WIDTH+3)'($signed(q_data.p0[j]))
                 + ((COORD_WIDTH+3)'($signed(q_data.p1[j])) <<< 2)
                 + ((COORD_WIDTH+3)'($signed(q_data.p1[j])) <<< 1)
                 + (COORD_WIDTH+3)'($signed(q_data.p2[j]));
         msum[j] = (COORD_WIDTH+1)'($signed(q_data.p1[j]))
                 + (COORD_WIDTH+1)'($signed(q_data.p2[j]));
         if (take_cur) begin
            res[j] = q_data.p2[j];
         end else if (take_vertex) begin
            res[j] = vsum[j][COORD_WIDTH+2:3];
         end else begin
            res[j] = msum[j][COORD_WIDTH:1];
         end
      end
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (valid_ff && rsp_pop) begin
         valid_in = 1'b0;
      end
      if (advance) begin
         valid_in           = 1'b1;
         out_in.out_x       = res[0];
         out_in.out_y       = res[1];
         out_in.out_z       = res[2];
         out_in.final_point = take_cur && q_data.last;
         step_in            = (step_ff == last_step) ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== hw/rtl/cubic_bspline_curve_subdivider_core.sv =====
// Top level of the cubic B-spline curve subdivider: front end, work queue and back end.
// One round of uniform cubic B-spline subdivision on a stream of 3D control points.
// A request is accepted in any cycle in which req_full is low; it yields one result
// for the first point of a curve, one (midpoint) for the second, two (vertex point,
// then edge midpoint) for each later point, plus the unchanged point flagged
// final_point on the request marked end_of_curve (a curve of a single point yields
// only that flagged point). Results leave one per cycle from the back end's output
// register while the consumer pops them, so an interior request holds the back end
// for both of its results; the first result of a request passes through its queue
// entry and then the output register. A two-entry queue lets requests keep arriving
// while a result waits to be popped.
module cubic_bspline_curve_subdivider_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  csub_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output csub_pkg::rsp_type rsp_data
);
   import csub_pkg::*;

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   work_type q_wr_data;
   work_type q_rd_data;

   csub_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   csub_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .full    (q_full),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rd_data)
   );

   csub_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/csub_checker.sv =====
// Port-level checks of the curve subdivider and the bind that attaches them.
module csub_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input csub_pkg::req_type req_data,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input csub_pkg::rsp_type rsp_data
);
   import csub_pkg::*;

   // Reset leaves no result waiting and room for a request.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   // The queue only fills while a result is waiting at the output.
   a_full_has_result: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("request side full with no result waiting");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_push |-> !$isunknown(req_data))
      else $error("request offered with unknown bits");

endmodule

bind cubic_bspline_curve_subdivider_core csub_checker u_checker (.*);
